/* hdl/ipid_pkg.sv */
package ipid_pkg;

  // Default widths for the top-level parameters
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 12;

  // Gain registers and derived coefficients
  localparam int COEF_W     = 24;
  localparam int COEF_SUM_W = COEF_W + 2;  // room for kp + 2*kd' - ki'
  localparam int OUT_W      = 32;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 2'd2;

  // Reset values of the gain registers (kp = 1.0 in Q12)
  localparam logic signed [COEF_W-1:0] PROP_GAIN_RESET  = 24'sd4096;
  localparam logic signed [COEF_W-1:0] INTEG_GAIN_RESET = 24'sd0;
  localparam logic signed [COEF_W-1:0] DERIV_GAIN_RESET = 24'sd0;

  // Output limits
  localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

  // Difference-equation coefficients
  typedef struct packed {
    logic signed [COEF_SUM_W-1:0] a0;
    logic signed [COEF_SUM_W-1:0] a1;
    logic signed [COEF_SUM_W-1:0] a2;
  } coef_t;

endpackage

/* hdl/ipid_in_if.sv */
interface ipid_in_if #(
  parameter int SAMPLE_WIDTH = ipid_pkg::DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] error_sample;
  logic                           first_sample;

  modport source (output valid, output error_sample, output first_sample, input ready);
  modport sink   (input valid, input error_sample, input first_sample, output ready);
endinterface

/* hdl/ipid_out_if.sv */
interface ipid_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ipid_pkg::OUT_W-1:0]    drive_out;
  logic                                 saturated;

  modport source (output valid, output drive_out, output saturated, input ready);
  modport sink   (input valid, input drive_out, input saturated, output ready);
endinterface

/* hdl/incremental_pid_controller.sv */
// Velocity-form PID: y[n] = y[n-1] + a0*e[n] - a1*e[n-1] + a2*e[n-2], saturated to 32 bits.
// The three products and the feedback add share one stage between input and result registers.
// Throughput: one item per cycle while drive_ch is ready.
// The history updates as the item leaves the input stage, so back-to-back items see it on time.
// Synchronous active-high reset: kp = 1.0, ki' = kd' = 0, history and last output cleared.
module incremental_pid_controller #(
  parameter int SAMPLE_WIDTH   = ipid_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = ipid_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ipid_pkg::COEF_W-1:0]          cfg_wdata,
  ipid_in_if.sink                              sample_ch,
  ipid_out_if.source                           drive_ch
);
  localparam int CW = ipid_pkg::COEF_SUM_W;

  // Gain registers
  logic signed [ipid_pkg::COEF_W-1:0] prop_gain, integ_gain, deriv_gain;
  ipid_pkg::coef_t                    coef;

  // Input stage
  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic                           s1_first;

  // History
  logic signed [SAMPLE_WIDTH-1:0]    err_d1, err_d2;
  logic signed [ipid_pkg::OUT_W-1:0] last_out;

  // Result stage
  logic                              out_valid;
  logic signed [ipid_pkg::OUT_W-1:0] drive;
  logic                              sat;

  logic                              s1_adv, in_xfer;
  logic signed [SAMPLE_WIDTH-1:0]    use_d1, use_d2;
  logic signed [ipid_pkg::OUT_W-1:0] use_last, y;
  logic                              y_sat;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= ipid_pkg::PROP_GAIN_RESET;
      integ_gain <= ipid_pkg::INTEG_GAIN_RESET;
      deriv_gain <= ipid_pkg::DERIV_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipid_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_wdata;
        ipid_pkg::REG_INTEG_GAIN: integ_gain <= cfg_wdata;
        ipid_pkg::REG_DERIV_GAIN: deriv_gain <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coefficients, registered from the gains
  always_ff @(posedge clk) begin
    coef.a0 <= CW'(prop_gain) + CW'(deriv_gain);
    coef.a1 <= CW'(prop_gain) + (CW'(deriv_gain) <<< 1) - CW'(integ_gain);
    coef.a2 <= CW'(deriv_gain);
  end

  // Handshake
  assign s1_adv          = s1_valid && (!out_valid || drive_ch.ready);
  assign sample_ch.ready = !s1_valid || !out_valid || drive_ch.ready;
  assign in_xfer         = sample_ch.valid && sample_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample <= sample_ch.error_sample;
      s1_first  <= sample_ch.first_sample;
    end
  end

  // A new run sees zero history
  assign use_d1   = s1_first ? '0 : err_d1;
  assign use_d2   = s1_first ? '0 : err_d2;
  assign use_last = s1_first ? '0 : last_out;

  ipid_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .coef     (coef),
    .err0     (s1_sample),
    .err1     (use_d1),
    .err2     (use_d2),
    .last_out (use_last),
    .y        (y),
    .sat      (y_sat)
  );

  // History update as the item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      err_d1   <= '0;
      err_d2   <= '0;
      last_out <= '0;
    end else if (s1_adv) begin
      err_d2   <= use_d1;
      err_d1   <= s1_sample;
      last_out <= y;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (drive_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive <= y;
      sat   <= y_sat;
    end
  end

  assign drive_ch.valid     = out_valid;
  assign drive_ch.drive_out = drive;
  assign drive_ch.saturated = sat;
endmodule

/* hdl/ipid_datapath.sv */
module ipid_datapath #(
  parameter int SAMPLE_WIDTH   = ipid_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = ipid_pkg::DEF_COEF_FRAC_BITS
) (
  input  ipid_pkg::coef_t                     coef,
  input  logic signed [SAMPLE_WIDTH-1:0]      err0,
  input  logic signed [SAMPLE_WIDTH-1:0]      err1,
  input  logic signed [SAMPLE_WIDTH-1:0]      err2,
  input  logic signed [ipid_pkg::OUT_W-1:0]   last_out,
  output logic signed [ipid_pkg::OUT_W-1:0]   y,
  output logic                                sat
);
  localparam int PROD_W = ipid_pkg::COEF_SUM_W + SAMPLE_WIDTH;
  localparam int TERM_W = PROD_W - COEF_FRAC_BITS;
  localparam int SUM_W  = ((TERM_W > ipid_pkg::OUT_W) ? TERM_W : ipid_pkg::OUT_W) + 2;

  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [TERM_W-1:0] t0, t1, t2;
  logic signed [SUM_W-1:0]  y_full;

  // Three independent products
  assign p0 = PROD_W'(coef.a0) * PROD_W'(err0);
  assign p1 = PROD_W'(coef.a1) * PROD_W'(err1);
  assign p2 = PROD_W'(coef.a2) * PROD_W'(err2);

  // Dropping the fraction bits of a two's-complement value floors it
  assign t0 = $signed(p0[PROD_W-1:COEF_FRAC_BITS]);
  assign t1 = $signed(p1[PROD_W-1:COEF_FRAC_BITS]);
  assign t2 = $signed(p2[PROD_W-1:COEF_FRAC_BITS]);

  // Full-precision sum with the previous output
  assign y_full = SUM_W'(last_out) + SUM_W'(t0) - SUM_W'(t1) + SUM_W'(t2);

  // Clip to 32 bits
  always_comb begin
    if (y_full > SUM_W'(ipid_pkg::OUT_MAX)) begin
      y   = ipid_pkg::OUT_MAX;
      sat = 1'b1;
    end else if (y_full < SUM_W'(ipid_pkg::OUT_MIN)) begin
      y   = ipid_pkg::OUT_MIN;
      sat = 1'b1;
    end else begin
      y   = y_full[ipid_pkg::OUT_W-1:0];
      sat = 1'b0;
    end
  end
endmodule

/* tb/sv/tb_incremental_pid_controller.sv */
`timescale 1ns / 100ps

module tb_incremental_pid_controller;

  localparam int SW   = ipid_pkg::DEF_SAMPLE_WIDTH;
  localparam int FRAC = ipid_pkg::DEF_COEF_FRAC_BITS;
  localparam int CW   = ipid_pkg::COEF_W;
  localparam int OW   = ipid_pkg::OUT_W;
  localparam int IW   = ipid_pkg::CFG_IDX_W;

  // Index 3 decodes to no register; writes there must be dropped
  localparam logic [IW-1:0] REG_UNUSED = 2'd3;

  localparam logic [CW-1:0] GAIN_MAX  = 24'h7F_FFFF;
  localparam logic [CW-1:0] GAIN_MIN  = 24'h80_0000;
  localparam logic [CW-1:0] GAIN_ZERO = 24'h00_0000;

  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 100;

  typedef struct {
    logic signed [SW-1:0] err;
    logic                 restart;
  } sample_t;

  typedef struct {
    logic signed [OW-1:0] drive;
    logic                 sat;
  } drive_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we;
  logic [IW-1:0]   cfg_index;
  logic [CW-1:0]   cfg_wdata;

  ipid_in_if #(.SAMPLE_WIDTH(SW)) sample_ch ();
  ipid_out_if                     drive_ch ();

  incremental_pid_controller #(
    .SAMPLE_WIDTH  (SW),
    .COEF_FRAC_BITS(FRAC)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .sample_ch(sample_ch),
    .drive_ch (drive_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Controller model: gains and history
  logic signed [CW-1:0] kp_q = ipid_pkg::PROP_GAIN_RESET;
  logic signed [CW-1:0] ki_q = ipid_pkg::INTEG_GAIN_RESET;
  logic signed [CW-1:0] kd_q = ipid_pkg::DERIV_GAIN_RESET;
  logic signed [SW-1:0] err_d1 = '0;
  logic signed [SW-1:0] err_d2 = '0;
  logic signed [OW-1:0] prev_drive = '0;

  sample_t pending_samples[$];
  drive_t  expected_drive[$];

  int queued_total   = 0;
  int accepted_total = 0;
  int fail_count     = 0;
  int idle_cycles    = 0;
  int sample_gap     = 0;
  int drive_stall    = 0;
  bit sample_fired   = 1'b0;
  bit drive_fired    = 1'b0;
  bit in_no_idle     = 1'b0;
  bit out_no_idle    = 1'b0;

  // Velocity-form update; floor shift of each product, then clip to 32 bits
  function automatic drive_t pid_step(input sample_t s);
    longint c0, c1, c2, acc;
    drive_t r;
    if (s.restart) begin
      err_d1     = '0;
      err_d2     = '0;
      prev_drive = '0;
    end
    c0  = longint'(kp_q) + longint'(kd_q);
    c1  = longint'(kp_q) + 2 * longint'(kd_q) - longint'(ki_q);
    c2  = longint'(kd_q);
    acc = longint'(prev_drive)
        + ((c0 * longint'(s.err)) >>> FRAC)
        - ((c1 * longint'(err_d1)) >>> FRAC)
        + ((c2 * longint'(err_d2)) >>> FRAC);
    r.sat = 1'b1;
    if (acc > longint'(ipid_pkg::OUT_MAX)) begin
      r.drive = ipid_pkg::OUT_MAX;
    end else if (acc < longint'(ipid_pkg::OUT_MIN)) begin
      r.drive = ipid_pkg::OUT_MIN;
    end else begin
      r.drive = acc[OW-1:0];
      r.sat   = 1'b0;
    end
    err_d2     = err_d1;
    err_d1     = s.err;
    prev_drive = r.drive;
    return r;
  endfunction

  function automatic logic [CW-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return GAIN_MAX;
      1: return GAIN_MIN;
      2: return GAIN_ZERO;
      3: return CW'(int'($urandom_range(0, 32768)) - 16384);
      default: return CW'($urandom);
    endcase
  endfunction

  // One register write; the model follows the same decode
  task automatic write_gain(input logic [IW-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ipid_pkg::REG_PROP_GAIN:  kp_q = val;
      ipid_pkg::REG_INTEG_GAIN: ki_q = val;
      ipid_pkg::REG_DERIV_GAIN: kd_q = val;
      default: ;
    endcase
  endtask

  task automatic queue_sample(input int err, input logic restart);
    sample_t s;
    s.err     = SW'(err);
    s.restart = restart;
    pending_samples.push_back(s);
    queued_total++;
  endtask

  // Block is idle once every queued sample went in and every result came out
  task automatic wait_idle();
    while (accepted_total != queued_total || expected_drive.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sample driver
  always @(negedge clk) begin : drive_samples
    sample_t nxt_sample;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_fired) begin
      sample_fired = 1'b0;
      if (sample_gap != 0) begin
        sample_gap--;
        sample_ch.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        nxt_sample = pending_samples.pop_front();
        sample_ch.error_sample <= nxt_sample.err;
        sample_ch.first_sample <= nxt_sample.restart;
        sample_ch.valid        <= 1'b1;
        sample_gap = in_no_idle ? 0 : $urandom_range(0, 9);
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Result backpressure: a fresh stall per result
  always @(negedge clk) begin
    if (rst) begin
      drive_ch.ready <= 1'b0;
    end else if (!drive_ch.ready || drive_fired) begin
      if (drive_fired) begin
        drive_fired = 1'b0;
        drive_stall = out_no_idle ? 0 : $urandom_range(0, 9);
      end
      if (drive_stall != 0) begin
        drive_stall--;
        drive_ch.ready <= 1'b0;
      end else begin
        drive_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on sample transfer, check on result transfer, watchdog
  always @(posedge clk) begin : monitor
    sample_t seen;
    drive_t  want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (sample_ch.valid && sample_ch.ready) begin
        sample_fired = 1'b1;
        idle_cycles  = 0;
        accepted_total++;
        seen.err     = sample_ch.error_sample;
        seen.restart = sample_ch.first_sample;
        expected_drive.push_back(pid_step(seen));
      end
      if (drive_ch.valid && drive_ch.ready) begin
        drive_fired = 1'b1;
        idle_cycles = 0;
        if (expected_drive.size() == 0) begin
          $error("unexpected result: drive_out %0d saturated %0b",
                 drive_ch.drive_out, drive_ch.saturated);
          fail_count++;
        end else begin
          want = expected_drive.pop_front();
          if (drive_ch.drive_out !== want.drive) begin
            $error("drive_out mismatch: expected %0d, got %0d", want.drive, drive_ch.drive_out);
            fail_count++;
          end
          if (drive_ch.saturated !== want.sat) begin
            $error("saturated mismatch: expected %0b, got %0b", want.sat, drive_ch.saturated);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int  odds_restart;
    int  err;
    bit  biased;
    bit  bias_pos;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.error_sample = '0;
    sample_ch.first_sample = 1'b0;
    drive_ch.ready         = 1'b0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Unknown index must leave the reset gains alone
    write_gain(REG_UNUSED, 24'h80_0001);

    // Reset gains: field extremes, restart mid-stream
    queue_sample(-32768, 1'b0);
    queue_sample(32767, 1'b0);
    queue_sample(32767, 1'b1);
    queue_sample(-32768, 1'b0);
    queue_sample(0, 1'b0);
    queue_sample(-1, 1'b0);
    queue_sample(1, 1'b1);
    queue_sample(-1, 1'b0);
    wait_idle();

    // Extreme gains, widest coefficients
    write_gain(ipid_pkg::REG_PROP_GAIN, GAIN_MAX);
    write_gain(ipid_pkg::REG_INTEG_GAIN, GAIN_MIN);
    write_gain(ipid_pkg::REG_DERIV_GAIN, GAIN_MAX);
    queue_sample(32767, 1'b1);
    queue_sample(32767, 1'b0);
    queue_sample(-32768, 1'b0);
    queue_sample(-32768, 1'b0);
    queue_sample(32767, 1'b0);
    queue_sample(0, 1'b0);
    queue_sample(-32768, 1'b1);
    queue_sample(-1, 1'b0);
    queue_sample(32767, 1'b0);
    queue_sample(12345, 1'b0);
    wait_idle();

    // Opposite extremes
    write_gain(ipid_pkg::REG_PROP_GAIN, GAIN_MIN);
    write_gain(ipid_pkg::REG_INTEG_GAIN, GAIN_MAX);
    write_gain(ipid_pkg::REG_DERIV_GAIN, GAIN_MIN);
    queue_sample(-32768, 1'b1);
    queue_sample(-32768, 1'b0);
    queue_sample(32767, 1'b0);
    queue_sample(-1, 1'b0);
    queue_sample(0, 1'b0);
    wait_idle();

    // Random phases; the first one is tuned to drive the output into both limits
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        write_gain(ipid_pkg::REG_PROP_GAIN, GAIN_MAX);
        write_gain(ipid_pkg::REG_INTEG_GAIN, GAIN_MAX);
        write_gain(ipid_pkg::REG_DERIV_GAIN, GAIN_ZERO);
        biased       = 1'b1;
        odds_restart = 1000;
      end else begin
        write_gain(ipid_pkg::REG_PROP_GAIN, pick_gain());
        write_gain(ipid_pkg::REG_INTEG_GAIN, pick_gain());
        write_gain(ipid_pkg::REG_DERIV_GAIN, pick_gain());
        biased       = 1'($urandom_range(0, 1));
        odds_restart = $urandom_range(0, 1) ? 20 : 200;
      end
      write_gain(REG_UNUSED, CW'($urandom));
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      bias_pos    = 1'($urandom_range(0, 1));

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 59) == 0)
          bias_pos = !bias_pos;
        if (biased && $urandom_range(0, 7) != 0)
          err = bias_pos ? int'($urandom_range(8192, 32767))
                         : -int'($urandom_range(8192, 32768));
        else
          err = int'($urandom);
        queue_sample(err, $urandom_range(0, odds_restart - 1) == 0);
      end
      wait_idle();
    end

    in_no_idle  = 1'b0;
    out_no_idle = 1'b0;
    repeat (8) @(negedge clk);

    if (expected_drive.size() != 0) begin
      $error("%0d expected results never arrived", expected_drive.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ipid_pkg.sv
hdl/ipid_in_if.sv
hdl/ipid_out_if.sv
hdl/ipid_datapath.sv
hdl/incremental_pid_controller.sv
tb/sv/tb_incremental_pid_controller.sv
